// File: rtl/core/sptrk_pkg.sv
// shared constants, types and helpers of the sliding pedestal tracker
package sptrk_pkg;

  localparam int DETECTORS = 8;
  localparam int CHANNELS  = 256;
  localparam int WINDOW    = 512;
  localparam int ADC_BITS  = 12;

  localparam int DET_W = 3;
  localparam int CH_W  = 8;
  localparam int ADC_W = 12;
  localparam int SG_W  = 15;
  localparam int SG_MAX = 2 ** SG_W - 1;
  localparam int FEW_DIV = 10;

  localparam int NCHAN  = DETECTORS * CHANNELS;
  localparam int CW     = $clog2(NCHAN);
  localparam int PW     = $clog2(WINDOW);
  localparam int AW     = $clog2(NCHAN * WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = ADC_BITS + PW + 1;
  localparam int SQS_W  = 2 * ADC_BITS + PW + 1;
  localparam int MW     = 2 * SUM_W;
  localparam int DV_W   = MW + 8;
  localparam int DS_W   = 2 * CNT_W;
  localparam int DVC_W  = $clog2(DV_W + 1);
  localparam int MQ_W   = ADC_BITS + 4;
  localparam int RT_W   = ADC_BITS + 4;
  localparam int SQI_W  = 2 * RT_W;
  localparam int RTC_W  = $clog2(RT_W + 1);
  localparam int H_W    = RT_W + 8;
  localparam int WORD_W = ADC_BITS + 1;

  localparam int HF_W       = 8;
  localparam int RP_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HIT_FACTOR    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFINE_PASSES = 1'd1;
  localparam logic [HF_W-1:0]      HF_RESET          = 8'd80;
  localparam logic [RP_W-1:0]      RP_RESET          = 4'd7;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] s;
    logic [SQS_W-1:0] s2;
    logic [CNT_W-1:0] n;
  } stats_req_t;

  typedef struct packed {
    logic            done;
    logic [MQ_W-1:0] mq;
    logic [RT_W-1:0] sq;
  } stats_rsp_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQS_W-1:0] sqs;
    logic [CNT_W-1:0] cnt;
    logic [PW-1:0]    pos;
    logic             full;
  } chan_state_t;

  localparam int ST_W = $bits(chan_state_t);

  function automatic logic [H_W-1:0] band_width(input logic [RT_W-1:0] sq,
                                                input logic [HF_W-1:0] hf);
    logic [H_W-1:0] prod;
    prod = H_W'(sq) * H_W'(hf);
    return (prod < H_W'(256)) ? H_W'(256) : prod;
  endfunction

  function automatic logic in_band(input logic [ADC_BITS-1:0] x,
                                   input logic [MQ_W+3:0] m,
                                   input logic [H_W-1:0] h);
    logic [MQ_W+3:0] xq;
    logic [MQ_W+3:0] diff;
    xq   = {x, 8'd0};
    diff = (xq > m) ? xq - m : m - xq;
    return H_W'(diff) <= h;
  endfunction

endpackage

// File: rtl/core/sptrk_if.sv
// valid/ready channel interfaces for samples and pedestal results
interface sptrk_in_if;
  logic                          valid;
  logic                          ready;
  logic [sptrk_pkg::DET_W-1:0]   detector;
  logic [sptrk_pkg::CH_W-1:0]    channel;
  logic [sptrk_pkg::ADC_W-1:0]   adc_sample;
  modport source (output valid, detector, channel, adc_sample, input ready);
  modport sink (input valid, detector, channel, adc_sample, output ready);
endinterface

interface sptrk_out_if;
  logic                         valid;
  logic                         ready;
  logic [sptrk_pkg::DET_W-1:0]  out_detector;
  logic [sptrk_pkg::CH_W-1:0]   out_channel;
  logic [15:0]                  pedestal_mean;
  logic [sptrk_pkg::SG_W-1:0]   pedestal_sigma;
  logic                         sample_used;
  logic                         window_ready;
  logic                         empty_sum;
  logic                         few_used;
  modport source (output valid, out_detector, out_channel, pedestal_mean, pedestal_sigma,
                  sample_used, window_ready, empty_sum, few_used, input ready);
  modport sink (input valid, out_detector, out_channel, pedestal_mean, pedestal_sigma,
                sample_used, window_ready, empty_sum, few_used, output ready);
endinterface

// File: rtl/core/sptrk_div.sv
// restoring divider, one quotient bit per cycle
module sptrk_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sptrk_pkg::DV_W-1:0]    dividend,
  input  logic [sptrk_pkg::DS_W-1:0]    divisor,
  output logic                          done,
  output logic [sptrk_pkg::DV_W-1:0]    quotient
);
  logic                          busy_r, busy_nxt, done_r, done_nxt;
  logic [sptrk_pkg::DVC_W-1:0]   cnt_r, cnt_nxt;
  logic [sptrk_pkg::DS_W-1:0]    rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [sptrk_pkg::DV_W-1:0]    quo_r, quo_nxt;
  logic [sptrk_pkg::DS_W:0]      rem_sh, rem_dif;
  logic                          ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[sptrk_pkg::DV_W-1]};
    rem_dif  = rem_sh - {1'b0, dvs_r};
    ge       = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_dif[sptrk_pkg::DS_W-1:0] : rem_sh[sptrk_pkg::DS_W-1:0];
      quo_nxt = {quo_r[sptrk_pkg::DV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sptrk_pkg::DVC_W'(sptrk_pkg::DV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// File: rtl/core/sptrk_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module sptrk_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sptrk_pkg::SQI_W-1:0]   radicand,
  output logic                          done,
  output logic [sptrk_pkg::RT_W-1:0]    root
);
  logic                          busy_r, busy_nxt, done_r, done_nxt;
  logic [sptrk_pkg::RTC_W-1:0]   cnt_r, cnt_nxt;
  logic [sptrk_pkg::SQI_W-1:0]   rad_r, rad_nxt;
  logic [sptrk_pkg::RT_W:0]      rem_r, rem_nxt;
  logic [sptrk_pkg::RT_W-1:0]    root_r, root_nxt;
  logic [sptrk_pkg::RT_W+2:0]    rem_sh, trial, rem_dif;
  logic                          ge;

  always_comb begin
    rem_sh   = {rem_r, rad_r[sptrk_pkg::SQI_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rem_dif  = rem_sh - trial;
    ge       = rem_sh >= trial;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[sptrk_pkg::SQI_W-3:0], 2'b00};
      rem_nxt  = ge ? rem_dif[sptrk_pkg::RT_W:0] : rem_sh[sptrk_pkg::RT_W:0];
      root_nxt = {root_r[sptrk_pkg::RT_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == sptrk_pkg::RTC_W'(sptrk_pkg::RT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// File: rtl/core/sptrk_stats.sv
// mean and sigma of a channel's used samples from its running sums
module sptrk_stats (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sptrk_pkg::stats_req_t   req,
  output sptrk_pkg::stats_rsp_t   rsp
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_DIV1 = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic                          done_r, done_nxt;
  logic [sptrk_pkg::SUM_W-1:0]   s_r, s_nxt;
  logic [sptrk_pkg::SQS_W-1:0]   s2_r, s2_nxt;
  logic [sptrk_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [sptrk_pkg::MW-1:0]      a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  logic [sptrk_pkg::DS_W-1:0]    nn_r, nn_nxt;
  logic [sptrk_pkg::MQ_W-1:0]    mq_r, mq_nxt;
  logic [sptrk_pkg::RT_W-1:0]    sq_r, sq_nxt;
  logic                          div_start, div_done, sqrt_start, sqrt_done;
  logic [sptrk_pkg::DV_W-1:0]    div_a, div_q;
  logic [sptrk_pkg::DS_W-1:0]    div_b;
  logic [sptrk_pkg::RT_W-1:0]    sqrt_root;

  sptrk_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  sptrk_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start),
    .radicand(div_q[sptrk_pkg::SQI_W-1:0]), .done(sqrt_done), .root(sqrt_root)
  );

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = 1'b0;
    s_nxt      = s_r;
    s2_nxt     = s2_r;
    n_nxt      = n_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    d_nxt      = d_r;
    nn_nxt     = nn_r;
    mq_nxt     = mq_r;
    sq_nxt     = sq_r;
    div_start  = 1'b0;
    div_a      = sptrk_pkg::DV_W'({s_r, 4'd0});
    div_b      = sptrk_pkg::DS_W'(n_r);
    sqrt_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          s_nxt  = req.s;
          s2_nxt = req.s2;
          n_nxt  = req.n;
          if (req.n == '0) begin
            mq_nxt   = '0;
            sq_nxt   = '0;
            done_nxt = 1'b1;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        a_nxt     = sptrk_pkg::MW'(n_r) * sptrk_pkg::MW'(s2_r);
        b_nxt     = sptrk_pkg::MW'(s_r) * sptrk_pkg::MW'(s_r);
        nn_nxt    = sptrk_pkg::DS_W'(n_r) * sptrk_pkg::DS_W'(n_r);
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        d_nxt     = (a_r > b_r) ? a_r - b_r : '0;
        div_start = 1'b1;
        state_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        div_a = {d_r, 8'd0};
        div_b = nn_r;
        if (div_done) begin
          mq_nxt    = div_q[sptrk_pkg::MQ_W-1:0];
          div_start = 1'b1;
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          sq_nxt    = sqrt_root;
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r  <= s_nxt;
    s2_r <= s2_nxt;
    n_r  <= n_nxt;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    d_r  <= d_nxt;
    nn_r <= nn_nxt;
    mq_r <= mq_nxt;
    sq_r <= sq_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.mq   = mq_r;
  assign rsp.sq   = sq_r;
endmodule

// File: rtl/core/sliding_pedestal_tracker_core.sv
// top level: channel state and sample window memories, item sequencer, window refinement
// a sliding update makes two passes through the stats unit (two 52-step divisions and a
//   16-step root each, none when the count is zero)
// the item that fills a window makes (refine_passes+2) sweeps over the window, each followed
//   by one stats run; one item is in work at a time, the next is taken once its result
//   has moved into the output register
// reset: after rst_n every entry of the channel state memory is cleared in turn, no beat is taken
module sliding_pedestal_tracker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  sptrk_in_if.sink                           in_if,
  sptrk_out_if.source                        out_if,
  input  logic                               cfg_we,
  input  logic [sptrk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sptrk_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RST  = 4'd2;
  localparam logic [3:0] S_RSM  = 4'd3;
  localparam logic [3:0] S_ST1  = 4'd4;
  localparam logic [3:0] S_BND  = 4'd5;
  localparam logic [3:0] S_UPD  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_PST  = 4'd10;
  localparam logic [3:0] S_PH   = 4'd11;
  localparam logic [3:0] S_PASS = 4'd12;

  localparam int SW  = sptrk_pkg::SUM_W;
  localparam int S2W = sptrk_pkg::SQS_W;
  localparam int NW  = sptrk_pkg::CNT_W;
  localparam int XW  = sptrk_pkg::ADC_BITS;

  // memories
  logic [sptrk_pkg::ST_W-1:0]   st_mem [sptrk_pkg::NCHAN];
  logic [sptrk_pkg::WORD_W-1:0] sm_mem [sptrk_pkg::NCHAN * sptrk_pkg::WINDOW];
  logic [sptrk_pkg::ST_W-1:0]   st_rdata_r;
  logic [sptrk_pkg::WORD_W-1:0] sm_rdata_r;
  logic                         st_we, sm_we;
  logic [sptrk_pkg::CW-1:0]     st_raddr, st_waddr;
  logic [sptrk_pkg::AW-1:0]     sm_raddr, sm_waddr;
  sptrk_pkg::chan_state_t       st_wdata, st_rd;
  logic [sptrk_pkg::WORD_W-1:0] sm_wdata;

  // control and payload registers
  logic [3:0]                   state_r, state_nxt;
  logic [sptrk_pkg::CW-1:0]     clr_r, clr_nxt, cidx_r, cidx_nxt;
  logic [sptrk_pkg::HF_W-1:0]   hf_r;
  logic [sptrk_pkg::RP_W-1:0]   rp_r, pass_r, pass_nxt;
  logic [sptrk_pkg::DET_W-1:0]  det_r, det_nxt;
  logic [sptrk_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [XW-1:0]                x_r, x_nxt, xrd;
  logic [sptrk_pkg::PW-1:0]     pos_r, pos_nxt, widx_r, widx_nxt;
  logic                         full_r, full_nxt;
  logic [SW-1:0]                s_r, s_nxt, acc_s_r, acc_s_nxt, s_upd;
  logic [S2W-1:0]               s2_r, s2_nxt, acc_s2_r, acc_s2_nxt, s2_upd;
  logic [NW-1:0]                n_r, n_nxt, acc_n_r, acc_n_nxt, n0_r, n0_nxt, n_upd;
  logic [sptrk_pkg::WORD_W-1:0] oldw_r, oldw_nxt;
  logic [sptrk_pkg::AW-1:0]     base_r, base_nxt, slot_r, slot_nxt;
  logic [NW-1:0]                ridx_r, ridx_nxt;
  logic                         rvld_r, rvld_nxt;
  logic [sptrk_pkg::MQ_W-1:0]   mq_r, mq_nxt;
  logic [sptrk_pkg::RT_W-1:0]   sq_r, sq_nxt;
  logic [sptrk_pkg::MQ_W+3:0]   m_r, m_nxt;
  logic [sptrk_pkg::H_W-1:0]    h_r, h_nxt;
  logic [2*XW-1:0]              xsq_r, xsq_nxt, osq_r, osq_nxt;
  logic                         used_r, used_nxt, u;
  logic [15:0]                  res_mean_r, res_mean_nxt;
  logic [sptrk_pkg::SG_W-1:0]   res_sigma_r, res_sigma_nxt;
  logic                         res_used_r, res_used_nxt, res_rdy_r, res_rdy_nxt;
  logic                         res_empty_r, res_empty_nxt, res_few_r, res_few_nxt;
  logic                         ov_r, ov_nxt;
  logic [sptrk_pkg::DET_W-1:0]  o_det_r;
  logic [sptrk_pkg::CH_W-1:0]   o_ch_r;
  logic [15:0]                  o_mean_r;
  logic [sptrk_pkg::SG_W-1:0]   o_sigma_r;
  logic                         o_used_r, o_rdy_r, o_empty_r, o_few_r, o_load;
  logic                         in_ok, in_take, sweep_end;
  logic [sptrk_pkg::CW-1:0]     in_c;
  sptrk_pkg::stats_req_t        sreq;
  sptrk_pkg::stats_rsp_t        srsp;

  sptrk_stats u_stats (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

  assign st_rd = sptrk_pkg::chan_state_t'(st_rdata_r);
  assign xrd   = sm_rdata_r[XW-1:0];
  assign in_ok = (int'(in_if.detector) < sptrk_pkg::DETECTORS) &&
                 (int'(in_if.channel) < sptrk_pkg::CHANNELS);
  assign in_c  = sptrk_pkg::CW'(int'(in_if.detector) * sptrk_pkg::CHANNELS +
                                int'(in_if.channel));
  assign in_if.ready = (state_r == S_IDLE);
  assign in_take     = in_if.valid && in_if.ready;
  assign sweep_end   = (ridx_r == NW'(sptrk_pkg::WINDOW)) && !rvld_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cidx_nxt  = cidx_r;
    pass_nxt  = pass_r;
    det_nxt   = det_r;
    ch_nxt    = ch_r;
    x_nxt     = x_r;
    pos_nxt   = pos_r;
    full_nxt  = full_r;
    s_nxt     = s_r;
    s2_nxt    = s2_r;
    n_nxt     = n_r;
    acc_s_nxt = acc_s_r;
    acc_s2_nxt = acc_s2_r;
    acc_n_nxt = acc_n_r;
    n0_nxt    = n0_r;
    oldw_nxt  = oldw_r;
    base_nxt  = base_r;
    slot_nxt  = slot_r;
    ridx_nxt  = ridx_r;
    rvld_nxt  = 1'b0;
    widx_nxt  = widx_r;
    mq_nxt    = mq_r;
    sq_nxt    = sq_r;
    m_nxt     = m_r;
    h_nxt     = h_r;
    xsq_nxt   = xsq_r;
    osq_nxt   = osq_r;
    used_nxt  = used_r;
    res_mean_nxt  = res_mean_r;
    res_sigma_nxt = res_sigma_r;
    res_used_nxt  = res_used_r;
    res_rdy_nxt   = res_rdy_r;
    res_empty_nxt = res_empty_r;
    res_few_nxt   = res_few_r;
    ov_nxt    = ov_r && !out_if.ready;
    o_load    = 1'b0;
    u         = 1'b0;
    s_upd     = '0;
    s2_upd    = '0;
    n_upd     = '0;
    st_we     = 1'b0;
    st_waddr  = cidx_r;
    st_wdata  = '0;
    st_raddr  = in_c;
    sm_we     = 1'b0;
    sm_waddr  = slot_r;
    sm_wdata  = '0;
    sm_raddr  = base_r + sptrk_pkg::AW'(ridx_r);
    sreq      = '0;

    // window sweep: issue reads, the read data returns in the next cycle
    if (state_r == S_SUM || state_r == S_PASS) begin
      if (ridx_r != NW'(sptrk_pkg::WINDOW)) begin
        ridx_nxt = ridx_r + 1'b1;
        rvld_nxt = 1'b1;
      end
    end

    case (state_r)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == sptrk_pkg::CW'(sptrk_pkg::NCHAN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take && in_ok) begin
          cidx_nxt  = in_c;
          det_nxt   = in_if.detector;
          ch_nxt    = in_if.channel;
          x_nxt     = in_if.adc_sample[XW-1:0];
          state_nxt = S_RST;
        end
      end
      S_RST: begin
        base_nxt  = sptrk_pkg::AW'(cidx_r) * sptrk_pkg::AW'(sptrk_pkg::WINDOW);
        slot_nxt  = base_nxt + sptrk_pkg::AW'(st_rd.pos);
        sm_raddr  = slot_nxt;
        pos_nxt   = st_rd.pos;
        full_nxt  = st_rd.full;
        s_nxt     = st_rd.sum;
        s2_nxt    = st_rd.sqs;
        n_nxt     = st_rd.cnt;
        state_nxt = S_RSM;
      end
      S_RSM: begin
        oldw_nxt = sm_rdata_r;
        if (!full_r) begin
          sm_we    = 1'b1;
          sm_wdata = {1'b0, x_r};
          if (pos_r != sptrk_pkg::PW'(sptrk_pkg::WINDOW - 1)) begin
            st_we         = 1'b1;
            st_wdata      = '{sum: s_r, sqs: s2_r, cnt: n_r, pos: pos_r + 1'b1, full: 1'b0};
            res_mean_nxt  = '0;
            res_sigma_nxt = '0;
            res_used_nxt  = 1'b0;
            res_rdy_nxt   = 1'b0;
            res_empty_nxt = 1'b0;
            res_few_nxt   = 1'b0;
            state_nxt     = S_OUT;
          end else begin
            ridx_nxt   = '0;
            acc_s_nxt  = '0;
            acc_s2_nxt = '0;
            acc_n_nxt  = '0;
            pass_nxt   = '0;
            state_nxt  = S_SUM;
          end
        end else begin
          sreq      = '{start: 1'b1, s: s_r, s2: s2_r, n: n_r};
          state_nxt = S_ST1;
        end
      end
      S_ST1: begin
        if (srsp.done) begin
          mq_nxt    = srsp.mq;
          sq_nxt    = srsp.sq;
          state_nxt = S_BND;
        end
      end
      S_BND: begin
        h_nxt     = sptrk_pkg::band_width(sq_r, hf_r);
        m_nxt     = {mq_r, 4'd0};
        xsq_nxt   = (2*XW)'(x_r) * (2*XW)'(x_r);
        osq_nxt   = (2*XW)'(oldw_r[XW-1:0]) * (2*XW)'(oldw_r[XW-1:0]);
        state_nxt = S_UPD;
      end
      S_UPD: begin
        u      = (n_r != '0) && sptrk_pkg::in_band(x_r, m_r, h_r);
        s_upd  = s_r - (oldw_r[XW] ? SW'(oldw_r[XW-1:0]) : '0) + (u ? SW'(x_r) : '0);
        s2_upd = s2_r - (oldw_r[XW] ? S2W'(osq_r) : '0) + (u ? S2W'(xsq_r) : '0);
        n_upd  = n_r - NW'(oldw_r[XW]) + NW'(u);
        pos_nxt = (pos_r == sptrk_pkg::PW'(sptrk_pkg::WINDOW - 1)) ? '0 : pos_r + 1'b1;
        sm_we    = 1'b1;
        sm_wdata = {u, x_r};
        st_we    = 1'b1;
        st_wdata = '{sum: s_upd, sqs: s2_upd, cnt: n_upd, pos: pos_nxt, full: 1'b1};
        used_nxt = u;
        s_nxt    = s_upd;
        s2_nxt   = s2_upd;
        n_nxt    = n_upd;
        sreq     = '{start: 1'b1, s: s_upd, s2: s2_upd, n: n_upd};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (srsp.done) begin
          res_mean_nxt  = srsp.mq;
          res_sigma_nxt = (srsp.sq > sptrk_pkg::RT_W'(sptrk_pkg::SG_MAX)) ?
                          sptrk_pkg::SG_W'(sptrk_pkg::SG_MAX) : srsp.sq[sptrk_pkg::SG_W-1:0];
          res_used_nxt  = used_r;
          res_rdy_nxt   = 1'b1;
          res_empty_nxt = (n_r == '0);
          res_few_nxt   = ((NW+4)'(n_r) * (NW+4)'(sptrk_pkg::FEW_DIV)) <
                          (NW+4)'(sptrk_pkg::WINDOW);
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_if.ready) begin
          o_load    = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        if (rvld_r) begin
          acc_s_nxt  = acc_s_r + SW'(xrd);
          acc_s2_nxt = acc_s2_r + S2W'((2*XW)'(xrd) * (2*XW)'(xrd));
          acc_n_nxt  = acc_n_r + 1'b1;
        end
        if (sweep_end) begin
          sreq      = '{start: 1'b1, s: acc_s_r, s2: acc_s2_r, n: acc_n_r};
          state_nxt = S_PST;
        end
      end
      S_PST: begin
        if (srsp.done) begin
          mq_nxt    = srsp.mq;
          sq_nxt    = srsp.sq;
          n0_nxt    = acc_n_r;
          state_nxt = S_PH;
        end
      end
      S_PH: begin
        h_nxt      = sptrk_pkg::band_width(sq_r, hf_r);
        m_nxt      = {mq_r, 4'd0};
        acc_s_nxt  = '0;
        acc_s2_nxt = '0;
        acc_n_nxt  = '0;
        ridx_nxt   = '0;
        widx_nxt   = '0;
        state_nxt  = S_PASS;
      end
      S_PASS: begin
        if (rvld_r) begin
          u        = (n0_r != '0) && sptrk_pkg::in_band(xrd, m_r, h_r);
          sm_we    = 1'b1;
          sm_waddr = base_r + sptrk_pkg::AW'(widx_r);
          sm_wdata = {u, xrd};
          widx_nxt = widx_r + 1'b1;
          if (u) begin
            acc_s_nxt  = acc_s_r + SW'(xrd);
            acc_s2_nxt = acc_s2_r + S2W'((2*XW)'(xrd) * (2*XW)'(xrd));
            acc_n_nxt  = acc_n_r + 1'b1;
          end
          if (widx_r == sptrk_pkg::PW'(sptrk_pkg::WINDOW - 1)) begin
            used_nxt = u;
          end
        end
        if (sweep_end) begin
          sreq = '{start: 1'b1, s: acc_s_r, s2: acc_s2_r, n: acc_n_r};
          if (pass_r == rp_r) begin
            st_we     = 1'b1;
            st_wdata  = '{sum: acc_s_r, sqs: acc_s2_r, cnt: acc_n_r, pos: '0, full: 1'b1};
            s_nxt     = acc_s_r;
            s2_nxt    = acc_s2_r;
            n_nxt     = acc_n_r;
            state_nxt = S_FIN;
          end else begin
            pass_nxt  = pass_r + 1'b1;
            state_nxt = S_PST;
          end
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_r <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata_r <= sm_mem[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      rvld_r  <= 1'b0;
      ov_r    <= 1'b0;
      hf_r    <= sptrk_pkg::HF_RESET;
      rp_r    <= sptrk_pkg::RP_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      rvld_r  <= rvld_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sptrk_pkg::CFG_HIT_FACTOR:    hf_r <= cfg_wdata[sptrk_pkg::HF_W-1:0];
          sptrk_pkg::CFG_REFINE_PASSES: rp_r <= cfg_wdata[sptrk_pkg::RP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cidx_r   <= cidx_nxt;
    pass_r   <= pass_nxt;
    det_r    <= det_nxt;
    ch_r     <= ch_nxt;
    x_r      <= x_nxt;
    pos_r    <= pos_nxt;
    full_r   <= full_nxt;
    s_r      <= s_nxt;
    s2_r     <= s2_nxt;
    n_r      <= n_nxt;
    acc_s_r  <= acc_s_nxt;
    acc_s2_r <= acc_s2_nxt;
    acc_n_r  <= acc_n_nxt;
    n0_r     <= n0_nxt;
    oldw_r   <= oldw_nxt;
    base_r   <= base_nxt;
    slot_r   <= slot_nxt;
    ridx_r   <= ridx_nxt;
    widx_r   <= widx_nxt;
    mq_r     <= mq_nxt;
    sq_r     <= sq_nxt;
    m_r      <= m_nxt;
    h_r      <= h_nxt;
    xsq_r    <= xsq_nxt;
    osq_r    <= osq_nxt;
    used_r   <= used_nxt;
    res_mean_r  <= res_mean_nxt;
    res_sigma_r <= res_sigma_nxt;
    res_used_r  <= res_used_nxt;
    res_rdy_r   <= res_rdy_nxt;
    res_empty_r <= res_empty_nxt;
    res_few_r   <= res_few_nxt;
    if (o_load) begin
      o_det_r   <= det_r;
      o_ch_r    <= ch_r;
      o_mean_r  <= res_mean_r;
      o_sigma_r <= res_sigma_r;
      o_used_r  <= res_used_r;
      o_rdy_r   <= res_rdy_r;
      o_empty_r <= res_empty_r;
      o_few_r   <= res_few_r;
    end
  end

  assign out_if.valid          = ov_r;
  assign out_if.out_detector   = o_det_r;
  assign out_if.out_channel    = o_ch_r;
  assign out_if.pedestal_mean  = o_mean_r;
  assign out_if.pedestal_sigma = o_sigma_r;
  assign out_if.sample_used    = o_used_r;
  assign out_if.window_ready   = o_rdy_r;
  assign out_if.empty_sum      = o_empty_r;
  assign out_if.few_used       = o_few_r;

`ifndef SYNTHESIS
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_if.ready)
    else $error("beat taken during state clear");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM || state_r == S_PASS) |-> (acc_n_r <= NW'(sptrk_pkg::WINDOW)))
    else $error("window count overflow");

  a_state_write: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == S_CLR || state_r == S_RSM || state_r == S_UPD ||
               state_r == S_PASS))
    else $error("channel state written in wrong phase");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !$past(ov_r)) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside output step");
`endif
endmodule
